// File: rtl/ckb_pkg.sv
// Shared types and constants for the color-keyed sprite blitter.
// No dependencies; every other file of the block imports this package.
package ckb_pkg;

	// Field widths fixed by the pixel and register formats
	localparam int PIX_W      = 32;
	localparam int KEY_W      = 24;
	localparam int POS_W      = 11;
	localparam int SIDE_W     = 11;
	localparam int PCT_W      = 7;
	localparam int SX_W       = 10;
	localparam int SY_W       = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_KEY     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PERCENT = 3'd6;

	// Pixel masks
	localparam logic [PIX_W-1:0] RGB_MASK  = 32'h00ff_ffff;
	localparam logic [PIX_W-1:0] RED_MASK  = 32'h00ff_0000;
	localparam logic [PIX_W-1:0] HALF_MASK = 32'h007f_7f7f;

	localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;

	typedef enum logic [1:0] {
		MODE_KEYED  = 2'd0,
		MODE_RED    = 2'd1,
		MODE_BLEND  = 2'd2,
		MODE_OPAQUE = 2'd3
	} ckb_mode_t;

	// Configuration as seen by the datapath (sides and percent already limited)
	typedef struct packed {
		logic [KEY_W-1:0]        color_key;
		ckb_mode_t               draw_mode;
		logic signed [POS_W-1:0] origin_x;
		logic signed [POS_W-1:0] origin_y;
		logic [SIDE_W-1:0]       width;
		logic [SIDE_W-1:0]       height;
		logic [PCT_W-1:0]        percent;
	} ckb_cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] sprite_pixel;
		logic [PIX_W-1:0] background_pixel;
	} ckb_in_t;

	typedef struct packed {
		logic             write_enable;
		logic [SX_W-1:0]  screen_x;
		logic [SY_W-1:0]  screen_y;
		logic [PIX_W-1:0] pixel_value;
		logic             last_pixel;
	} ckb_out_t;

endpackage

// File: rtl/ckb_if.sv
// Valid/ready channel interfaces of the sprite blitter: pixel input,
// result output and configuration write. Depends on ckb_pkg.
interface ckb_pixel_if import ckb_pkg::*; ();
	logic    valid;
	logic    ready;
	ckb_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ckb_result_if import ckb_pkg::*; ();
	logic     valid;
	logic     ready;
	ckb_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ckb_cfg_if import ckb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/ckb_cfg_regs.sv
// Configuration register file of the sprite blitter, with side clamping
// and percent saturation. Depends on ckb_pkg and ckb_if.
module ckb_cfg_regs import ckb_pkg::*; #(
	parameter int MAX_SPRITE_SIDE = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	ckb_cfg_if.sink  cfg,
	output ckb_cfg_t cfg_o
);

	localparam int CMP_W = 14;

	logic [KEY_W-1:0]        color_key_q;
	ckb_mode_t               draw_mode_q;
	logic signed [POS_W-1:0] origin_x_q;
	logic signed [POS_W-1:0] origin_y_q;
	logic [SIDE_W-1:0]       width_q;
	logic [SIDE_W-1:0]       height_q;
	logic [PCT_W-1:0]        percent_q;

	assign cfg.ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_key_q <= KEY_W'(24'hff_ffff);
			draw_mode_q <= MODE_KEYED;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			width_q     <= SIDE_W'(1);
			height_q    <= SIDE_W'(1);
			percent_q   <= FULL_PERCENT;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_COLOR_KEY:     color_key_q <= cfg.wdata[KEY_W-1:0];
				REG_DRAW_MODE:     draw_mode_q <= ckb_mode_t'(cfg.wdata[1:0]);
				REG_ORIGIN_X:      origin_x_q  <= $signed(cfg.wdata[POS_W-1:0]);
				REG_ORIGIN_Y:      origin_y_q  <= $signed(cfg.wdata[POS_W-1:0]);
				REG_SPRITE_WIDTH:  width_q     <= cfg.wdata[SIDE_W-1:0];
				REG_SPRITE_HEIGHT: height_q    <= cfg.wdata[SIDE_W-1:0];
				REG_WIDTH_PERCENT: percent_q   <= cfg.wdata[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero side reads as one, oversize as the maximum side
	function automatic logic [SIDE_W-1:0] side_limit(input logic [SIDE_W-1:0] s);
		logic [SIDE_W-1:0] r;
		r = s;
		if (s == '0)
			r = SIDE_W'(1);
		else if (CMP_W'(s) > CMP_W'(MAX_SPRITE_SIDE))
			r = SIDE_W'(MAX_SPRITE_SIDE);
		return r;
	endfunction

	always_comb begin
		cfg_o.color_key = color_key_q;
		cfg_o.draw_mode = draw_mode_q;
		cfg_o.origin_x  = origin_x_q;
		cfg_o.origin_y  = origin_y_q;
		cfg_o.width     = side_limit(width_q);
		cfg_o.height    = side_limit(height_q);
		cfg_o.percent   = (percent_q > FULL_PERCENT) ? FULL_PERCENT : percent_q;
	end

endmodule

// File: rtl/ckb_scan.sv
// Input register stage: takes one pixel transaction, tags it with the
// sprite column and row, advances the raster counters. Depends on ckb_pkg, ckb_if.
module ckb_scan import ckb_pkg::*; #(
	parameter int CW = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	ckb_pixel_if.sink         pixel,
	input  ckb_cfg_t          cfg_i,
	input  logic              adv,
	output logic              valid_s1,
	output ckb_in_t           data_s1,
	output logic [CW-1:0]     col_s1,
	output logic [CW-1:0]     row_s1,
	output logic              last_s1
);

	localparam int LW = ((CW > SIDE_W) ? CW : SIDE_W) + 1;

	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic          accept;
	logic          last_col;
	logic          last_row;

	assign pixel.ready = !valid_s1 || adv;
	assign accept      = pixel.valid && pixel.ready;

	// A counter at or past its bound wraps
	assign last_col = (LW'(col_q) + LW'(1)) >= LW'(cfg_i.width);
	assign last_row = (LW'(row_q) + LW'(1)) >= LW'(cfg_i.height);

	// Stage valid and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + CW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= pixel.data;
			col_s1  <= col_q;
			row_s1  <= row_q;
			last_s1 <= last_col && last_row;
		end
	end

endmodule

// File: rtl/ckb_pixel_stage.sv
// Result stage: clipping, color-key test and draw-mode pixel forming,
// into the output register. Depends on ckb_pkg and ckb_if.
module ckb_pixel_stage import ckb_pkg::*; #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480,
	parameter int CW            = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ckb_cfg_t      cfg_i,
	input  logic          valid_s1,
	input  ckb_in_t       data_s1,
	input  logic [CW-1:0] col_s1,
	input  logic [CW-1:0] row_s1,
	input  logic          last_s1,
	output logic          adv,
	ckb_result_if.source  result
);

	localparam int PW = ((CW > POS_W) ? CW : POS_W) + 3;
	localparam int DW = ((CW > SIDE_W) ? CW : SIDE_W) + 8;

	logic                 valid_s2;
	ckb_out_t             data_s2;
	logic                 load;
	logic signed [PW-1:0] sx;
	logic signed [PW-1:0] sy;
	logic                 on_screen;
	logic                 in_width;
	logic                 keyed;
	logic                 we;
	logic [DW-1:0]        col_scaled;
	logic [DW-1:0]        width_scaled;
	logic [PIX_W-1:0]     pix;
	ckb_out_t             res;

	assign load   = !valid_s2 || result.ready;
	assign adv    = valid_s1 && load;
	assign result.valid = valid_s2;
	assign result.data  = data_s2;

	// Screen position and clipping
	assign sx = PW'(cfg_i.origin_x) + $signed(PW'(col_s1));
	assign sy = PW'(cfg_i.origin_y) + $signed(PW'(row_s1));
	assign on_screen = !sx[PW-1] && (sx[PW-2:0] < (PW-1)'(SCREEN_WIDTH))
	                && !sy[PW-1] && (sy[PW-2:0] < (PW-1)'(SCREEN_HEIGHT));

	// column < floor(width * percent / 100)  <=>  100 * (column + 1) <= width * percent
	assign col_scaled   = (DW'(col_s1) + DW'(1)) * DW'(FULL_PERCENT);
	assign width_scaled = DW'(cfg_i.width) * DW'(cfg_i.percent);
	assign in_width     = col_scaled <= width_scaled;

	assign keyed = (cfg_i.draw_mode != MODE_OPAQUE)
	            && ((data_s1.sprite_pixel & RGB_MASK) == PIX_W'(cfg_i.color_key));
	assign we = on_screen && in_width && !keyed;

	// Pixel by draw mode
	always_comb begin
		case (cfg_i.draw_mode)
			MODE_RED:   pix = data_s1.sprite_pixel & RED_MASK;
			MODE_BLEND: pix = ((data_s1.sprite_pixel >> 1) & HALF_MASK)
			                + ((data_s1.background_pixel >> 1) & HALF_MASK);
			default:    pix = data_s1.sprite_pixel;
		endcase
	end

	always_comb begin
		res.write_enable = we;
		res.screen_x     = we ? sx[SX_W-1:0] : '0;
		res.screen_y     = we ? sy[SY_W-1:0] : '0;
		res.pixel_value  = we ? pix : '0;
		res.last_pixel   = last_s1;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (load)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv)
			data_s2 <= res;
	end

endmodule

// File: rtl/color_key_sprite_blitter_unit.sv
// Top level of the color-keyed, clipped sprite blitter.
// Depends on ckb_pkg, ckb_if, ckb_cfg_regs, ckb_scan and ckb_pixel_stage.
//
// Feed the sprite in raster order, one sprite pixel with the background
// pixel beneath it per transaction; one result comes back per pixel, and a
// new pixel is taken every clock while the result side is ready. The
// pipeline is an input register (which also holds the raster counters) and
// an output register, so a stalled result does not stop the next pixel from
// entering. Pixels off screen, past the scaled width or matching the color
// key outside opaque mode come back with write_enable low and zero position
// and value; the last pixel of the sprite is flagged and the counters
// restart. Write registers only while no pixel is in flight.
module color_key_sprite_blitter_unit import ckb_pkg::*; #(
	parameter int SCREEN_WIDTH    = 640,
	parameter int SCREEN_HEIGHT   = 480,
	parameter int MAX_SPRITE_SIDE = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	ckb_cfg_if.sink      cfg,
	ckb_pixel_if.sink    pixel,
	ckb_result_if.source result
);

	localparam int CW = (MAX_SPRITE_SIDE > 1) ? $clog2(MAX_SPRITE_SIDE) : 1;

	ckb_cfg_t      cfg_cur;
	logic          valid_s1;
	ckb_in_t       data_s1;
	logic [CW-1:0] col_s1;
	logic [CW-1:0] row_s1;
	logic          last_s1;
	logic          adv;

	ckb_cfg_regs #(
		.MAX_SPRITE_SIDE(MAX_SPRITE_SIDE)
	) u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.cfg_o (cfg_cur)
	);

	ckb_scan #(
		.CW(CW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pixel),
		.cfg_i   (cfg_cur),
		.adv     (adv),
		.valid_s1(valid_s1),
		.data_s1 (data_s1),
		.col_s1  (col_s1),
		.row_s1  (row_s1),
		.last_s1 (last_s1)
	);

	ckb_pixel_stage #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.CW           (CW)
	) u_pix (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_i   (cfg_cur),
		.valid_s1(valid_s1),
		.data_s1 (data_s1),
		.col_s1  (col_s1),
		.row_s1  (row_s1),
		.last_s1 (last_s1),
		.adv     (adv),
		.result  (result)
	);

endmodule

// File: test/ckb_sprite_checker.sv
// Scoreboard for the color-keyed sprite blitter: watches the configuration,
// pixel and result channels, predicts each result and compares it field by field.
// Depends on ckb_pkg and the channel interfaces in ckb_if.
module ckb_sprite_checker import ckb_pkg::*; #(
	parameter int SCREEN_WIDTH    = 640,
	parameter int SCREEN_HEIGHT   = 480,
	parameter int MAX_SPRITE_SIDE = 1024
) (
	input  logic  clk,
	input  logic  arst_n,
	ckb_cfg_if    cfg,
	ckb_pixel_if  pixel,
	ckb_result_if result,
	output int    pending,
	output int    fails
);

	// Shadow copy of the block's registers and raster counters
	logic [KEY_W-1:0]        key;
	ckb_mode_t               mode;
	logic signed [POS_W-1:0] org_x;
	logic signed [POS_W-1:0] org_y;
	logic [SIDE_W-1:0]       spr_w;
	logic [SIDE_W-1:0]       spr_h;
	logic [PCT_W-1:0]        pct;
	int                      col;
	int                      row;

	// Predicted blit results, oldest first
	ckb_out_t blit_q[$];
	ckb_out_t oldest;

	// Zero counts as one, oversize is capped
	function automatic int limit_side(logic [SIDE_W-1:0] s);
		if (s == 0)
			return 1;
		if (s > MAX_SPRITE_SIDE)
			return MAX_SPRITE_SIDE;
		return int'(s);
	endfunction

	// Destination write for one sprite pixel; advances the raster counters
	function automatic ckb_out_t blit_pixel(ckb_in_t px);
		int       w;
		int       h;
		int       p;
		int       drawn;
		int       sx;
		int       sy;
		logic     visible;
		logic     keyed;
		logic     last_col;
		ckb_out_t r;
		w = limit_side(spr_w);
		h = limit_side(spr_h);
		p = (pct > FULL_PERCENT) ? int'(FULL_PERCENT) : int'(pct);
		drawn = (w * p) / int'(FULL_PERCENT);
		sx = int'(org_x) + col;
		sy = int'(org_y) + row;
		visible = sx >= 0 && sx < SCREEN_WIDTH && sy >= 0 && sy < SCREEN_HEIGHT
			&& col < drawn;
		keyed = mode != MODE_OPAQUE && (px.sprite_pixel & RGB_MASK) == {8'h00, key};
		last_col = col + 1 >= w;
		r = '0;
		r.last_pixel = last_col && row + 1 >= h;
		if (visible && !keyed) begin
			r.write_enable = 1'b1;
			r.screen_x = sx[SX_W-1:0];
			r.screen_y = sy[SY_W-1:0];
			case (mode)
				MODE_RED:   r.pixel_value = px.sprite_pixel & RED_MASK;
				MODE_BLEND: r.pixel_value = ((px.sprite_pixel >> 1) & HALF_MASK)
					+ ((px.background_pixel >> 1) & HALF_MASK);
				default:    r.pixel_value = px.sprite_pixel;
			endcase
		end
		// a counter at or past a shrunken bound wraps like the last column/row
		if (last_col) begin
			col = 0;
			row = r.last_pixel ? 0 : row + 1;
		end else begin
			col++;
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key = RGB_MASK[KEY_W-1:0];
			mode = MODE_KEYED;
			org_x = '0;
			org_y = '0;
			spr_w = SIDE_W'(1);
			spr_h = SIDE_W'(1);
			pct = FULL_PERCENT;
			col = 0;
			row = 0;
			fails = 0;
			blit_q.delete();
			pending <= 0;
		end else begin
			// register write transaction
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_COLOR_KEY:     key = cfg.wdata[KEY_W-1:0];
					REG_DRAW_MODE:     mode = ckb_mode_t'(cfg.wdata[1:0]);
					REG_ORIGIN_X:      org_x = cfg.wdata[POS_W-1:0];
					REG_ORIGIN_Y:      org_y = cfg.wdata[POS_W-1:0];
					REG_SPRITE_WIDTH:  spr_w = cfg.wdata[SIDE_W-1:0];
					REG_SPRITE_HEIGHT: spr_h = cfg.wdata[SIDE_W-1:0];
					REG_WIDTH_PERCENT: pct = cfg.wdata[PCT_W-1:0];
					default: ;
				endcase
			end

			// pixel transaction: queue its prediction
			if (pixel.valid && pixel.ready)
				blit_q.push_back(blit_pixel(pixel.data));

			// result transaction: compare with the oldest prediction
			if (result.valid && result.ready) begin
				if (blit_q.size() == 0) begin
					$error("result transaction with no pixel outstanding");
					fails++;
				end else begin
					oldest = blit_q.pop_front();
					check_field("write_enable", PIX_W'(oldest.write_enable),
						PIX_W'(result.data.write_enable));
					check_field("screen_x", PIX_W'(oldest.screen_x),
						PIX_W'(result.data.screen_x));
					check_field("screen_y", PIX_W'(oldest.screen_y),
						PIX_W'(result.data.screen_y));
					check_field("pixel_value", oldest.pixel_value,
						result.data.pixel_value);
					check_field("last_pixel", PIX_W'(oldest.last_pixel),
						PIX_W'(result.data.last_pixel));
				end
			end
			pending <= blit_q.size();
		end
	end

endmodule

// File: test/tb_color_key_sprite_blitter_unit.sv
// Testbench top for color_key_sprite_blitter_unit: clock, reset, register
// setup, pixel stimulus with random gaps and result back-pressure, verdict.
// Depends on ckb_pkg, ckb_if, the blitter RTL and ckb_sprite_checker.
module tb_color_key_sprite_blitter_unit import ckb_pkg::*; ;

	localparam int SCREEN_W     = 640;
	localparam int SCREEN_H     = 480;
	localparam int MAX_SIDE     = 1024;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 8;
	localparam int SEGMENTS     = 12;

	logic             clk;
	logic             arst_n;
	int               src_idle_pct;
	int               sink_idle_pct;
	int               hold_asked;
	int               pending;
	int               fails;
	logic [KEY_W-1:0] cur_key;

	ckb_cfg_if    cfg_ch();
	ckb_pixel_if  pix_ch();
	ckb_result_if res_ch();

	color_key_sprite_blitter_unit #(
		.SCREEN_WIDTH    (SCREEN_W),
		.SCREEN_HEIGHT   (SCREEN_H),
		.MAX_SPRITE_SIDE (MAX_SIDE)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.pixel  (pix_ch),
		.result (res_ch)
	);

	ckb_sprite_checker #(
		.SCREEN_WIDTH    (SCREEN_W),
		.SCREEN_HEIGHT   (SCREEN_H),
		.MAX_SPRITE_SIDE (MAX_SIDE)
	) i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.pixel   (pix_ch),
		.result  (res_ch),
		.pending (pending),
		.fails   (fails)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Register write transaction; valid is left high for a following write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
	endtask

	task automatic set_config(logic [KEY_W-1:0] key, ckb_mode_t mode, int ox, int oy,
			int w, int h, int pct);
		cur_key = key;
		write_reg(REG_COLOR_KEY, CFG_DATA_W'(key));
		write_reg(REG_DRAW_MODE, CFG_DATA_W'(mode));
		write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox[POS_W-1:0]));
		write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy[POS_W-1:0]));
		write_reg(REG_SPRITE_WIDTH, CFG_DATA_W'(w[SIDE_W-1:0]));
		write_reg(REG_SPRITE_HEIGHT, CFG_DATA_W'(h[SIDE_W-1:0]));
		write_reg(REG_WIDTH_PERCENT, CFG_DATA_W'(pct[PCT_W-1:0]));
		cfg_ch.valid <= 1'b0;
	endtask

	// Pixel transaction with random idle cycles ahead of it
	task automatic send_pixel(logic [PIX_W-1:0] spr, logic [PIX_W-1:0] bg);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.data <= '{sprite_pixel: spr, background_pixel: bg};
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
	endtask

	// Stop offering pixels and wait until every result is back
	task automatic drain();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Origin around the screen edges, in the interior, or anywhere
	function automatic int pick_origin(int extent);
		case ($urandom_range(3))
			0:       return int'($urandom_range(2047)) - 1024;
			1:       return int'($urandom_range(40)) - 20;
			2:       return extent - 20 + int'($urandom_range(25));
			default: return int'($urandom_range(extent - 40));
		endcase
	endfunction

	// Result side: random stalls plus a long hold on request
	initial begin
		int hold_left;
		int hold_done;
		hold_left = 0;
		hold_done = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_done != hold_asked) begin
				hold_left = HOLD_CYCLES;
				hold_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Watchdog on cycles without any transaction
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	// Stimulus
	initial begin
		int               phase;
		int               n;
		int               w;
		int               h;
		int               pct;
		logic [KEY_W-1:0] key;
		logic [PIX_W-1:0] spr;
		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_COLOR_KEY;
		cfg_ch.wdata <= '0;
		pix_ch.valid <= 1'b0;
		pix_ch.data <= '0;
		hold_asked <= 0;
		src_idle_pct = 7;
		sink_idle_pct <= 56;
		cur_key = RGB_MASK[KEY_W-1:0];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 1x1 sprite at the origin, white key
		send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
		send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
		drain();

		// blend at the bottom-right corner, across the right edge, black key
		set_config('0, MODE_BLEND, SCREEN_W - 3, SCREEN_H - 2, 4, 2, 100);
		send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
		send_pixel(32'hFF00_0000, 32'h0000_0000);
		send_pixel(32'h8081_8283, 32'h0101_0101);
		send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(32'h00FF_FFFF, 32'hFF00_0000);
		send_pixel(32'h0000_0001, 32'h0000_0001);
		send_pixel(32'h7F7F_7F7F, 32'h8080_8080);
		drain();

		// red only across the top-left corner, percent above full
		set_config(RGB_MASK[KEY_W-1:0], MODE_RED, -1, -1, 3, 2, 127);
		send_pixel(32'hFFFF_FFFF, 32'h0);
		send_pixel(32'h12FF_3456, 32'h0);
		send_pixel(32'hFFFF_FFFF, 32'h0);
		send_pixel(32'h00AB_CDEF, 32'h0);
		send_pixel(32'hFF80_0000, 32'h0);
		send_pixel(32'h0000_FFFF, 32'h0);
		drain();

		// opaque, far off screen, oversize width, zero height, zero percent
		set_config(24'hABCDEF, MODE_OPAQUE, -1024, 1023, 2047, 0, 0);
		repeat (3) send_pixel(32'h00AB_CDEF, 32'hFFFF_FFFF);
		drain();

		// width shrinks below the running column; key matches but opaque draws
		set_config(24'hABCDEF, MODE_OPAQUE, 0, SCREEN_H - 1, 2, 1, 50);
		repeat (3) send_pixel(32'hFFAB_CDEF, 32'h0);

		// random part: idling phases of four segments each
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			phase = seg / 4;
			drain();
			case (phase)
				0: begin
					src_idle_pct = 7;
					sink_idle_pct <= 56;
				end
				1: begin
					src_idle_pct = 56;
					sink_idle_pct <= 7;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct <= 0;
				end
			endcase

			key = KEY_W'($urandom());
			case ($urandom_range(7))
				0:       key = '0;
				1:       key = '1;
				default: ;
			endcase
			w = ($urandom_range(7) == 0) ? int'($urandom_range(2047))
				: int'($urandom_range(1, 12));
			h = ($urandom_range(7) == 0) ? int'($urandom_range(2047))
				: int'($urandom_range(1, 6));
			case ($urandom_range(3))
				0:       pct = $urandom_range(127);
				1:       pct = $urandom_range(25, 99);
				default: pct = 100;
			endcase
			set_config(key, ckb_mode_t'($urandom_range(3)), pick_origin(SCREEN_W),
				pick_origin(SCREEN_H), w, h, pct);

			// long result hold so the pipeline fills and stalls its input
			if (seg == 1)
				hold_asked <= hold_asked + 1;

			n = $urandom_range(24, 44);
			repeat (n) begin
				spr = $urandom();
				if ($urandom_range(3) == 0)
					spr[KEY_W-1:0] = cur_key;
				send_pixel(spr, $urandom());
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
